// File: rtl/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// shared types and constants of the slotted page store
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int unsigned PAGE_BYTES_DEF = 4096;
  localparam int unsigned MAX_SLOTS_DEF  = 256;
  localparam int unsigned HDR_BYTES      = 4;
  localparam int unsigned SLOT_BYTES     = 4;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_READ   = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_NO_SPACE  = 2'd1,
    STAT_NO_RECORD = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_LOOK,
    S_RD_DATA,
    S_DEL_LOOK,
    S_DEL_MOVE,
    S_DEL_DIR
  } state_e;

  typedef struct packed {
    logic accept;
    logic rd_look;
    logic rd_emit;
    logic del_look;
    logic del_move;
    logic del_dir;
  } cmd_t;

  typedef struct packed {
    logic slot_ok;
    logic move_done;
    logic dir_done;
    logic out_busy;
  } stat_t;

endpackage

// File: rtl/sps_ctrl.sv
// ----------------------------------------------------------------------------
// sps_ctrl
// sequencer for insert, read, delete compaction and clear
// ----------------------------------------------------------------------------
module sps_ctrl
  import sps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] kind_i,
  input  stat_t      stat_i,
  output logic       in_stall_o,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE) | stat_i.out_busy;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.accept = in_valid_i & ~in_stall_o;
        if (cmd_o.accept && stat_i.slot_ok) begin
          if (kind_e'(kind_i) == KIND_READ) begin
            state_d = S_RD_LOOK;
          end else if (kind_e'(kind_i) == KIND_DELETE) begin
            state_d = S_DEL_LOOK;
          end
        end
      end
      S_RD_LOOK: begin
        cmd_o.rd_look = 1'b1;
        state_d       = S_RD_DATA;
      end
      S_RD_DATA: begin
        cmd_o.rd_emit = 1'b1;
        state_d       = S_IDLE;
      end
      S_DEL_LOOK: begin
        cmd_o.del_look = 1'b1;
        state_d        = S_DEL_MOVE;
      end
      S_DEL_MOVE: begin
        cmd_o.del_move = 1'b1;
        if (stat_i.move_done) begin
          state_d = S_DEL_DIR;
        end
      end
      S_DEL_DIR: begin
        cmd_o.del_dir = 1'b1;
        if (stat_i.dir_done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// File: rtl/sps_datapath.sv
// ----------------------------------------------------------------------------
// sps_datapath
// page memory, slot directory, page pointers and result register
// ----------------------------------------------------------------------------
module sps_datapath
  import sps_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int unsigned MAX_SLOTS  = MAX_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [7:0]  slot_index_i,
  input  logic [11:0] byte_offset_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  read_byte_o,
  output logic [7:0]  assigned_slot_o,
  output logic [8:0]  record_count_o,
  output logic [12:0] free_pointer_o
);

  localparam int AW  = $clog2(PAGE_BYTES);
  localparam int PW  = $clog2(PAGE_BYTES + 1);
  localparam int PW1 = PW + 1;
  localparam int SW  = $clog2(MAX_SLOTS);
  localparam int CW  = $clog2(MAX_SLOTS + 1);
  localparam int EW  = ((PW > CW + 3) ? PW : CW + 3) + 1;
  localparam int XW  = (CW > 8) ? CW : 8;
  localparam int BW  = ((PW > 12) ? PW : 12) + 1;

  logic [7:0]    page_mem [PAGE_BYTES];
  logic [PW-1:0] off_mem  [MAX_SLOTS];
  logic [PW-1:0] len_mem  [MAX_SLOTS];

  logic          pg_we;
  logic [AW-1:0] pg_wa, pg_ra;
  logic [7:0]    pg_wd, pg_rdata_q;
  logic          sm_we;
  logic [SW-1:0] sm_wa, sm_ra;
  logic [PW-1:0] sm_woff, sm_wlen, sm_roff_q, sm_rlen_q;

  logic [CW-1:0] held_q, held_d;
  logic [PW-1:0] free_q, free_d;
  logic [PW-1:0] pend_q, pend_d;
  logic          povf_q, povf_d;
  logic          mv_v_q, mv_v_d;
  logic          dv_q, dv_d;
  logic          rok_q, rok_d;
  logic          out_valid_q;

  logic [11:0]   boff_q, boff_d;
  logic [PW-1:0] doff_q, doff_d, dlen_q, dlen_d;
  logic [SW-1:0] dslot_q, dslot_d;
  logic [PW-1:0] mv_src_q, mv_src_d;
  logic [AW-1:0] mv_wa_q, mv_wa_d;
  logic [CW-1:0] di_q, di_d;
  logic [SW-1:0] dwa_q, dwa_d;

  logic          emit;
  status_e       r_status;
  logic [7:0]    r_byte, r_slot;
  status_e       status_q;
  logic [7:0]    read_byte_q, slot_q;
  logic [8:0]    count_q;
  logic [12:0]   fp_q;

  logic          full, ovf0, fits, slot_ok, boff_ok, move_done, dir_done;
  logic [EW-1:0] reserved;
  logic [PW-1:0] pend_n, free_new;
  logic [BW-1:0] pos;
  logic [PW1-1:0] fsum;
  logic [CW-1:0] dir_src;

  assign full     = held_q >= CW'(MAX_SLOTS);
  assign ovf0     = povf_q | full;
  assign reserved = EW'(HDR_BYTES) + EW'(SLOT_BYTES) * (EW'(held_q) + EW'(1));
  assign fits     = (EW'(pend_q) + EW'(1) + reserved) <= EW'(free_q);
  assign slot_ok  = XW'(slot_index_i) < XW'(held_q);
  assign boff_ok  = BW'(boff_q) < BW'(sm_rlen_q);
  assign pos      = BW'(sm_roff_q) + BW'(sm_rlen_q) - BW'(1) - BW'(boff_q);
  assign fsum     = PW1'(free_q) + PW1'(dlen_q);
  assign dir_src  = (di_q < CW'(dslot_q)) ? di_q : di_q + CW'(1);
  assign move_done = (mv_src_q == free_q) && !mv_v_q;
  assign dir_done  = (di_q == held_q - CW'(1)) && !dv_q;

  assign stat_o.slot_ok   = slot_ok;
  assign stat_o.move_done = move_done;
  assign stat_o.dir_done  = dir_done;
  assign stat_o.out_busy  = out_valid_q & out_stall_i;

  always_comb begin
    held_d   = held_q;
    free_d   = free_q;
    pend_d   = pend_q;
    povf_d   = povf_q;
    mv_v_d   = 1'b0;
    dv_d     = 1'b0;
    rok_d    = rok_q;
    boff_d   = boff_q;
    doff_d   = doff_q;
    dlen_d   = dlen_q;
    dslot_d  = dslot_q;
    mv_src_d = mv_src_q;
    mv_wa_d  = mv_wa_q;
    di_d     = di_q;
    dwa_d    = dwa_q;
    pg_we    = 1'b0;
    pg_wa    = mv_wa_q;
    pg_wd    = pg_rdata_q;
    pg_ra    = AW'(mv_src_q - PW'(1));
    sm_we    = 1'b0;
    sm_wa    = dwa_q;
    sm_woff  = sm_roff_q;
    sm_wlen  = sm_rlen_q;
    sm_ra    = SW'(dir_src);
    emit     = 1'b0;
    r_status = STAT_DONE;
    r_byte   = '0;
    r_slot   = '0;
    pend_n   = pend_q;
    free_new = free_q;

    if (cmd_i.accept) begin
      unique case (kind_e'(kind_i))
        KIND_INSERT: begin
          if (!ovf0) begin
            if (fits) begin
              pg_we  = 1'b1;
              pg_wa  = AW'(free_q - PW'(1) - pend_q);
              pg_wd  = data_byte_i;
              pend_n = pend_q + PW'(1);
            end else begin
              povf_d = 1'b1;
            end
          end else begin
            povf_d = 1'b1;
            if (pend_q < PW'(PAGE_BYTES)) begin
              pend_n = pend_q + PW'(1);
            end
          end
          pend_d = pend_n;
          if (last_byte_i) begin
            emit = 1'b1;
            if (povf_d || full) begin
              r_status = STAT_NO_SPACE;
            end else begin
              free_new = free_q - pend_n;
              free_d   = free_new;
              sm_we    = 1'b1;
              sm_wa    = SW'(held_q);
              sm_woff  = free_new;
              sm_wlen  = pend_n;
              held_d   = held_q + CW'(1);
              r_slot   = 8'(held_q);
            end
            pend_d = '0;
            povf_d = 1'b0;
          end
        end
        KIND_READ: begin
          if (!slot_ok) begin
            emit     = 1'b1;
            r_status = STAT_NO_RECORD;
          end else begin
            sm_ra  = SW'(slot_index_i);
            boff_d = byte_offset_i;
          end
        end
        KIND_DELETE: begin
          pend_d = '0;
          povf_d = 1'b0;
          if (!slot_ok) begin
            emit     = 1'b1;
            r_status = STAT_NO_RECORD;
          end else begin
            sm_ra   = SW'(slot_index_i);
            dslot_d = SW'(slot_index_i);
          end
        end
        KIND_CLEAR: begin
          pend_d = '0;
          povf_d = 1'b0;
          held_d = '0;
          free_d = PW'(PAGE_BYTES);
          emit   = 1'b1;
        end
        default: ;
      endcase
    end

    if (cmd_i.rd_look) begin
      pg_ra = AW'(pos);
      rok_d = boff_ok && (pos < BW'(PAGE_BYTES));
    end

    if (cmd_i.rd_emit) begin
      emit     = 1'b1;
      r_status = rok_q ? STAT_DONE : STAT_NO_RECORD;
      r_byte   = rok_q ? pg_rdata_q : 8'd0;
    end

    if (cmd_i.del_look) begin
      doff_d = sm_roff_q;
      dlen_d = sm_rlen_q;
      di_d   = '0;
      if ((sm_roff_q > free_q) &&
          (PW1'(sm_roff_q) + PW1'(sm_rlen_q) <= PW1'(PAGE_BYTES))) begin
        mv_src_d = sm_roff_q;
      end else begin
        mv_src_d = free_q;
      end
    end

    if (cmd_i.del_move) begin
      if (mv_v_q) begin
        pg_we = 1'b1;
      end
      if (mv_src_q != free_q) begin
        mv_src_d = mv_src_q - PW'(1);
        mv_v_d   = 1'b1;
        mv_wa_d  = AW'(PW1'(mv_src_q) - PW1'(1) + PW1'(dlen_q));
      end
    end

    if (cmd_i.del_dir) begin
      if (dv_q) begin
        sm_we = 1'b1;
        if (sm_roff_q < doff_q) begin
          sm_woff = PW'(PW1'(sm_roff_q) + PW1'(dlen_q));
        end
      end
      if (di_q != held_q - CW'(1)) begin
        di_d  = di_q + CW'(1);
        dv_d  = 1'b1;
        dwa_d = SW'(di_q);
      end
      if (dir_done) begin
        held_d = held_q - CW'(1);
        free_d = (fsum > PW1'(PAGE_BYTES)) ? PW'(PAGE_BYTES) : PW'(fsum);
        emit   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pg_we) begin
      page_mem[pg_wa] <= pg_wd;
    end
    pg_rdata_q <= page_mem[pg_ra];
  end

  always_ff @(posedge clk_i) begin
    if (sm_we) begin
      off_mem[sm_wa] <= sm_woff;
      len_mem[sm_wa] <= sm_wlen;
    end
    sm_roff_q <= off_mem[sm_ra];
    sm_rlen_q <= len_mem[sm_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      free_q      <= PW'(PAGE_BYTES);
      pend_q      <= '0;
      povf_q      <= 1'b0;
      mv_v_q      <= 1'b0;
      dv_q        <= 1'b0;
      rok_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      held_q      <= held_d;
      free_q      <= free_d;
      pend_q      <= pend_d;
      povf_q      <= povf_d;
      mv_v_q      <= mv_v_d;
      dv_q        <= dv_d;
      rok_q       <= rok_d;
      out_valid_q <= emit | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    boff_q   <= boff_d;
    doff_q   <= doff_d;
    dlen_q   <= dlen_d;
    dslot_q  <= dslot_d;
    mv_src_q <= mv_src_d;
    mv_wa_q  <= mv_wa_d;
    di_q     <= di_d;
    dwa_q    <= dwa_d;
    if (emit) begin
      status_q    <= r_status;
      read_byte_q <= r_byte;
      slot_q      <= r_slot;
      count_q     <= 9'(held_d);
      fp_q        <= 13'(free_d);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign read_byte_o     = read_byte_q;
  assign assigned_slot_o = slot_q;
  assign record_count_o  = count_q;
  assign free_pointer_o  = fp_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten");

  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CW'(MAX_SLOTS))
    else $error("record count beyond directory size");

  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= PW'(PAGE_BYTES))
    else $error("free pointer beyond page");

  a_move_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mv_v_q |-> $past(cmd_i.del_move))
    else $error("page move write without move step");

endmodule

// File: rtl/slotted_page_store.sv
// ----------------------------------------------------------------------------
// slotted_page_store
// database page with a slot directory, byte-wise insert, read and delete
// ----------------------------------------------------------------------------
// Insert and clear transactions leave the sequencer idle, so record bytes
// stream in at one per cycle while the result register is free. A read goes
// through a slot directory read and then a page memory read, both registered.
// A delete holds the input while the record bytes below the deleted record
// move up through the single page memory port pair, and then while the
// directory of held records is shifted one entry a cycle. The page and the
// directory need no clearing pass after reset.
module slotted_page_store
  import sps_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int unsigned MAX_SLOTS  = MAX_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [7:0]  slot_index_i,
  input  logic [11:0] byte_offset_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  read_byte_o,
  output logic [7:0]  assigned_slot_o,
  output logic [8:0]  record_count_o,
  output logic [12:0] free_pointer_o
);

  cmd_t  cmd;
  stat_t stat;

  sps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  sps_datapath #(
    .PAGE_BYTES (PAGE_BYTES),
    .MAX_SLOTS  (MAX_SLOTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .kind_i          (kind_i),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .slot_index_i    (slot_index_i),
    .byte_offset_i   (byte_offset_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .read_byte_o     (read_byte_o),
    .assigned_slot_o (assigned_slot_o),
    .record_count_o  (record_count_o),
    .free_pointer_o  (free_pointer_o)
  );

endmodule

// File: sim/page_store_checker.sv
// ----------------------------------------------------------------------------
// page_store_checker
// watches both channels of the slotted page store, predicts every result from
// its own copy of the page and directory, and compares in order
// ----------------------------------------------------------------------------
module page_store_checker
  import sps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [7:0]  slot_index_i,
  input  logic [11:0] byte_offset_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  status_i,
  input  logic [7:0]  read_byte_i,
  input  logic [7:0]  assigned_slot_i,
  input  logic [8:0]  record_count_i,
  input  logic [12:0] free_pointer_i,
  output int          fail_count_o,
  output int          pending_results_o,
  output int          held_records_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PAGE = PAGE_BYTES_DEF;
  localparam int unsigned SLOTS = MAX_SLOTS_DEF;

  typedef struct packed {
    status_e     status;
    logic [7:0]  rbyte;
    logic [7:0]  slot;
    logic [8:0]  count;
    logic [12:0] fptr;
  } page_result_t;

  page_result_t result_q[$];
  logic [7:0]   page_mem[PAGE];
  int unsigned  rec_off[SLOTS];
  int unsigned  rec_len[SLOTS];
  int unsigned  rec_count;
  int unsigned  top_free;
  int unsigned  part_len;
  bit           part_over;
  int           fails;

  assign fail_count_o      = fails;
  assign pending_results_o = result_q.size();
  assign held_records_o    = rec_count;

  task automatic push_result(status_e st, logic [7:0] rb, logic [7:0] sl);
    page_result_t r;
    r.status = st;
    r.rbyte  = rb;
    r.slot   = sl;
    r.count  = rec_count[8:0];
    r.fptr   = top_free[12:0];
    result_q.push_back(r);
  endtask

  task automatic apply_item(kind_e k, logic [7:0] d, logic lst, logic [7:0] si,
                            logic [11:0] bo);
    int unsigned rsv, pos, off, len, i;
    case (k)
      KIND_INSERT: begin
        rsv = HDR_BYTES + SLOT_BYTES * (rec_count + 1);
        if (rec_count >= SLOTS) part_over = 1;
        if (!part_over) begin
          if (part_len + 1 + rsv <= top_free) begin
            page_mem[top_free - 1 - part_len] = d;
            part_len++;
          end else begin
            part_over = 1;
          end
        end else if (part_len < PAGE) begin
          part_len++;
        end
        if (lst) begin
          if (part_over || rec_count >= SLOTS) begin
            push_result(STAT_NO_SPACE, 8'd0, 8'd0);
          end else begin
            top_free -= part_len;
            rec_off[rec_count] = top_free;
            rec_len[rec_count] = part_len;
            rec_count++;
            push_result(STAT_DONE, 8'd0, 8'(rec_count - 1));
          end
          part_len  = 0;
          part_over = 0;
        end
      end
      KIND_READ: begin
        if (si >= rec_count || bo >= rec_len[si]) begin
          push_result(STAT_NO_RECORD, 8'd0, 8'd0);
        end else begin
          pos = rec_off[si] + rec_len[si] - 1 - bo;
          if (pos >= PAGE) push_result(STAT_NO_RECORD, 8'd0, 8'd0);
          else push_result(STAT_DONE, page_mem[pos], 8'd0);
        end
      end
      KIND_DELETE: begin
        part_len  = 0;
        part_over = 0;
        if (si >= rec_count) begin
          push_result(STAT_NO_RECORD, 8'd0, 8'd0);
        end else begin
          off = rec_off[si];
          len = rec_len[si];
          if (off > top_free && off + len <= PAGE)
            for (i = off - top_free; i > 0; i--)
              page_mem[top_free + len + i - 1] = page_mem[top_free + i - 1];
          for (i = 0; i < rec_count; i++)
            if (rec_off[i] < off) rec_off[i] += len;
          for (i = si; i + 1 < rec_count; i++) begin
            rec_off[i] = rec_off[i + 1];
            rec_len[i] = rec_len[i + 1];
          end
          rec_count--;
          top_free += len;
          if (top_free > PAGE) top_free = PAGE;
          push_result(STAT_DONE, 8'd0, 8'd0);
        end
      end
      default: begin
        part_len  = 0;
        part_over = 0;
        for (i = 0; i < PAGE; i++) page_mem[i] = 8'd0;
        rec_count = 0;
        top_free  = PAGE;
        push_result(STAT_DONE, 8'd0, 8'd0);
      end
    endcase
  endtask

  initial begin
    for (int i = 0; i < PAGE; i++) page_mem[i] = 8'd0;
    for (int i = 0; i < SLOTS; i++) begin
      rec_off[i] = 0;
      rec_len[i] = 0;
    end
    rec_count = 0;
    top_free  = PAGE;
    part_len  = 0;
    part_over = 0;
    fails     = 0;
  end

  always @(posedge clk_i) begin
    page_result_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%t unexpected result transaction status=%0d", $realtime, status_i);
        end else begin
          want = result_q.pop_front();
          if (status_i !== want.status || read_byte_i !== want.rbyte ||
              assigned_slot_i !== want.slot || record_count_i !== want.count ||
              free_pointer_i !== want.fptr) begin
            fails++;
            if (fails <= 10)
              $display({"%t result mismatch exp st=%0d rb=%0h sl=%0d cnt=%0d fp=%0d",
                        " act st=%0d rb=%0h sl=%0d cnt=%0d fp=%0d"},
                       $realtime, want.status, want.rbyte, want.slot, want.count,
                       want.fptr, status_i, read_byte_i, assigned_slot_i,
                       record_count_i, free_pointer_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        apply_item(kind_e'(kind_i), data_byte_i, last_byte_i, slot_index_i,
                   byte_offset_i);
    end
  end

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// stimulus for the slotted page store: random record traffic with idling and a
// long receiver hold-off, after directed corner cases and a full directory
// ----------------------------------------------------------------------------
module testbench
  import sps_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 40000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = KIND_CLEAR;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic [7:0]  slot_index = '0;
  logic [11:0] byte_offset = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [7:0]  read_byte;
  logic [7:0]  assigned_slot;
  logic [8:0]  record_count;
  logic [12:0] free_pointer;
  int          fail_count;
  int          pending_results;
  int          held_records;
  bit          calm = 0;
  bit          hold_req = 0;
  int          idle_cycles = 0;

  always #5 clk = ~clk;

  slotted_page_store u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .kind_i(kind), .data_byte_i(data_byte), .last_byte_i(last_byte),
    .slot_index_i(slot_index), .byte_offset_i(byte_offset),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .read_byte_o(read_byte), .assigned_slot_o(assigned_slot),
    .record_count_o(record_count), .free_pointer_o(free_pointer)
  );

  page_store_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .kind_i(kind), .data_byte_i(data_byte), .last_byte_i(last_byte),
    .slot_index_i(slot_index), .byte_offset_i(byte_offset),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .status_i(status), .read_byte_i(read_byte), .assigned_slot_i(assigned_slot),
    .record_count_i(record_count), .free_pointer_i(free_pointer),
    .fail_count_o(fail_count), .pending_results_o(pending_results),
    .held_records_o(held_records)
  );

  // receiver side, random stall plus a counted long hold-off
  always @(posedge clk) begin
    int hold_left;
    bit hold_taken;
    if (!hold_req) begin
      hold_taken = 1'b0;
    end else if (!hold_taken) begin
      hold_left  = 400;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 12);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send(kind_e k, logic [7:0] d, logic lst, logic [7:0] si,
                      logic [11:0] bo);
    while (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    data_byte   <= d;
    last_byte   <= lst;
    slot_index  <= si;
    byte_offset <= bo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_record(int unsigned len);
    for (int unsigned i = 1; i <= len; i++)
      send(KIND_INSERT, 8'($urandom), i == len, 8'($urandom), 12'($urandom));
  endtask

  function automatic logic [7:0] pick_slot();
    if (held_records > 0 && $urandom_range(99) < 85)
      return 8'($urandom_range(held_records - 1));
    return 8'($urandom);
  endfunction

  function automatic logic [11:0] pick_offset();
    if ($urandom_range(99) < 85) return 12'($urandom_range(30));
    return 12'($urandom);
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned sent;
    int unsigned sel;
    bit          hold_done;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    send(KIND_CLEAR, 8'hFF, 1'b1, 8'hFF, 12'hFFF);
    send(KIND_READ, 8'h00, 1'b0, 8'd0, 12'd0);
    send(KIND_DELETE, 8'h00, 1'b0, 8'd0, 12'd0);
    send(KIND_INSERT, 8'h00, 1'b1, 8'hFF, 12'hFFF);
    send(KIND_INSERT, 8'hFF, 1'b0, 8'h00, 12'h000);
    send(KIND_INSERT, 8'hA5, 1'b0, 8'h00, 12'h000);
    send(KIND_INSERT, 8'h5A, 1'b1, 8'h00, 12'h000);
    send(KIND_READ, 8'h00, 1'b0, 8'd1, 12'd0);
    send(KIND_READ, 8'h00, 1'b0, 8'd1, 12'd2);
    send(KIND_READ, 8'h00, 1'b0, 8'd1, 12'd3);
    send(KIND_READ, 8'h00, 1'b0, 8'd255, 12'hFFF);
    send(KIND_INSERT, 8'h11, 1'b0, 8'h00, 12'h000);
    send(KIND_READ, 8'h00, 1'b0, 8'd0, 12'd0);
    send(KIND_INSERT, 8'h22, 1'b1, 8'h00, 12'h000);
    send(KIND_READ, 8'h00, 1'b0, 8'd2, 12'd1);
    send(KIND_INSERT, 8'h33, 1'b0, 8'h00, 12'h000);
    send(KIND_DELETE, 8'h00, 1'b0, 8'd0, 12'd0);
    send(KIND_READ, 8'h00, 1'b0, 8'd0, 12'd1);
    send(KIND_INSERT, 8'h44, 1'b0, 8'h00, 12'h000);
    send(KIND_CLEAR, 8'h00, 1'b0, 8'd0, 12'd0);
    send(KIND_INSERT, 8'h55, 1'b1, 8'h00, 12'h000);
    send(KIND_DELETE, 8'h00, 1'b0, 8'd0, 12'd0);
    send(KIND_DELETE, 8'h00, 1'b0, 8'd255, 12'd0);

    // fill the directory with one-byte records, the last one refused
    calm = 1;
    for (int i = 0; i < 257; i++) send_record(1);
    send(KIND_READ, 8'h00, 1'b0, 8'd255, 12'd0);
    send(KIND_DELETE, 8'h00, 1'b0, 8'd128, 12'd0);
    send(KIND_DELETE, 8'h00, 1'b0, 8'd0, 12'd0);
    calm = 0;
    send(KIND_CLEAR, 8'h00, 1'b0, 8'd0, 12'd0);

    sent      = 0;
    hold_done = 0;
    while (sent < 420) begin
      if (!hold_done && sent >= 150) begin
        wait_drained();
        hold_req = 1;
        for (int i = 0; i < 40; i++) begin
          send(KIND_READ, 8'($urandom), 1'($urandom), pick_slot(), pick_offset());
        end
        hold_req  = 0;
        hold_done = 1;
        sent += 40;
      end
      calm = (sent >= 250 && sent < 320);
      sel = $urandom_range(99);
      if (sel < 50) begin
        if ($urandom_range(99) < 5) sel = $urandom_range(120, 40);
        else sel = $urandom_range(24, 1);
        send_record(sel);
        sent += sel;
      end else if (sel < 55) begin
        sel = $urandom_range(5, 1);
        send_record(sel);
        send(KIND_INSERT, 8'($urandom), 1'b0, 8'($urandom), 12'($urandom));
        sent += sel + 1;
      end else if (sel < 83) begin
        send(KIND_READ, 8'($urandom), 1'($urandom), pick_slot(), pick_offset());
        sent++;
      end else if (sel < 97) begin
        send(KIND_DELETE, 8'($urandom), 1'($urandom), pick_slot(), 12'($urandom));
        sent++;
      end else begin
        send(KIND_CLEAR, 8'($urandom), 1'($urandom), 8'($urandom), 12'($urandom));
        sent++;
      end
    end
    calm = 0;

    wait_drained();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
